FILE: hw/rtl/crx_pkg.sv
`default_nettype none

package crx_pkg;

    // Field widths
    localparam int ID_W      = 8;
    localparam int DATA_W    = 56;
    localparam int CR_W      = 16;
    localparam int MAXLEN_W  = 9;
    localparam int BYTES_W   = 9;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DAT_W = 16;

    // Result buffer depth and count width
    localparam int RES_MAX   = 3;
    localparam int RES_CNT_W = 2;

    // Timer width default
    localparam int TIMER_BITS_DEF = 16;

    // Input operation codes
    localparam logic OP_FRAME = 1'b0;
    localparam logic OP_TICK  = 1'b1;

    // Frame types from the PCI high nibble
    localparam logic [3:0] PCI_SF = 4'd0;
    localparam logic [3:0] PCI_FF = 4'd1;
    localparam logic [3:0] PCI_CF = 4'd2;

    // Result kinds
    localparam logic [2:0] KIND_CHUNK = 3'd0;
    localparam logic [2:0] KIND_FIRST = 3'd1;
    localparam logic [2:0] KIND_DONE  = 3'd2;
    localparam logic [2:0] KIND_ERROR = 3'd3;
    localparam logic [2:0] KIND_FC    = 3'd4;

    // Error codes
    localparam logic [1:0] ERR_NONE    = 2'd0;
    localparam logic [1:0] ERR_TIMEOUT = 2'd1;
    localparam logic [1:0] ERR_SEQ     = 2'd2;

    // Flow control status
    localparam logic FC_CTS      = 1'b0;
    localparam logic FC_OVERFLOW = 1'b1;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_PHYSICAL_ID     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_SIZE      = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SEPARATION_TIME = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_CR_TIMEOUT_MS   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_LENGTH      = 3'd4;

    // Configuration reset values
    localparam logic [7:0]          PHYSICAL_ID_RST     = 8'd0;
    localparam logic [7:0]          BLOCK_SIZE_RST      = 8'd8;
    localparam logic [7:0]          SEPARATION_TIME_RST = 8'd20;
    localparam logic [CR_W-1:0]     CR_TIMEOUT_RST      = 16'd150;
    localparam logic [MAXLEN_W-1:0] MAX_LENGTH_RST      = 9'd256;

    typedef struct packed {
        logic              op;
        logic [ID_W-1:0]   can_id;
        logic [7:0]        pci_byte;
        logic [DATA_W-1:0] frame_data;
    } frame_t;

    typedef struct packed {
        logic [2:0]        kind;
        logic [ID_W-1:0]   msg_id;
        logic [7:0]        msg_length;
        logic [7:0]        chunk_offset;
        logic [DATA_W-1:0] chunk_data;
        logic [2:0]        chunk_count;
        logic [1:0]        error_code;
        logic              fc_status;
        logic [7:0]        fc_block;
        logic [7:0]        fc_stmin;
        logic              last;
    } result_t;

    typedef struct packed {
        logic [ID_W-1:0]     physical_id;
        logic [7:0]          block_size;
        logic [7:0]          separation_time;
        logic [CR_W-1:0]     cr_timeout_ms;
        logic [MAXLEN_W-1:0] max_length;
    } cfg_t;

    typedef result_t [RES_MAX-1:0] result_set_t;

    // Keep the lowest n bytes of a data word
    function automatic logic [DATA_W-1:0] low_bytes(input logic [DATA_W-1:0] d,
                                                    input logic [2:0] n);
        logic [DATA_W-1:0] r;
        r = '0;
        for (int i = 0; i < DATA_W / 8; i++) begin
            if (3'(i) < n) begin
                r[i*8 +: 8] = d[i*8 +: 8];
            end
        end
        return r;
    endfunction

    function automatic result_t mk_chunk(input logic [ID_W-1:0] id, input logic [7:0] len,
                                         input logic [7:0] off,
                                         input logic [DATA_W-1:0] data,
                                         input logic [2:0] cnt);
        result_t r;
        r = '0;
        r.kind         = KIND_CHUNK;
        r.msg_id       = id;
        r.msg_length   = len;
        r.chunk_offset = off;
        r.chunk_data   = data;
        r.chunk_count  = cnt;
        return r;
    endfunction

    function automatic result_t mk_plain(input logic [2:0] kind, input logic [ID_W-1:0] id,
                                         input logic [7:0] len);
        result_t r;
        r = '0;
        r.kind       = kind;
        r.msg_id     = id;
        r.msg_length = len;
        return r;
    endfunction

    function automatic result_t mk_error(input logic [ID_W-1:0] id, input logic [7:0] len,
                                         input logic [1:0] code);
        result_t r;
        r = '0;
        r.kind       = KIND_ERROR;
        r.msg_id     = id;
        r.msg_length = len;
        r.error_code = code;
        return r;
    endfunction

    function automatic result_t mk_fc(input logic [ID_W-1:0] id, input logic [7:0] len,
                                      input logic st, input logic [7:0] bs,
                                      input logic [7:0] stmin);
        result_t r;
        r = '0;
        r.kind       = KIND_FC;
        r.msg_id     = id;
        r.msg_length = len;
        r.fc_status  = st;
        r.fc_block   = bs;
        r.fc_stmin   = stmin;
        return r;
    endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/crx_proc.sv
`default_nettype none

module crx_proc
    import crx_pkg::*;
#(
    parameter int TIMER_BITS = TIMER_BITS_DEF
)(
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    fire,
    input  wire frame_t                  item,
    input  wire cfg_t                    cfg,
    output      result_set_t             res,
    output      logic [RES_CNT_W-1:0]    res_count
);

    localparam int CMP_W = (TIMER_BITS > CR_W) ? TIMER_BITS : CR_W;

    logic                  receiving_reg,       receiving_next;
    logic [3:0]            expected_seq_reg,    expected_seq_next;
    logic [BYTES_W-1:0]    bytes_received_reg,  bytes_received_next;
    logic [7:0]            declared_length_reg, declared_length_next;
    logic [ID_W-1:0]       sender_id_reg,       sender_id_next;
    logic [7:0]            block_left_reg,      block_left_next;
    logic [TIMER_BITS-1:0] gap_timer_reg,       gap_timer_next;

    logic [3:0]            frame_type;
    logic [3:0]            pci_low;
    logic [7:0]            ff_len;
    logic [TIMER_BITS-1:0] gap_inc;
    logic                  tick_expired;
    logic                  gap_expired;
    logic [BYTES_W-1:0]    remaining;
    logic [7:0]            block_dec;

    // Decode the item and build its results against the current state
    always_comb
    begin
        res                  = '0;
        res_count            = '0;
        receiving_next       = receiving_reg;
        expected_seq_next    = expected_seq_reg;
        bytes_received_next  = bytes_received_reg;
        declared_length_next = declared_length_reg;
        sender_id_next       = sender_id_reg;
        block_left_next      = block_left_reg;
        gap_timer_next       = gap_timer_reg;

        frame_type   = item.pci_byte[7:4];
        pci_low      = item.pci_byte[3:0];
        ff_len       = item.frame_data[7:0];
        gap_inc      = (gap_timer_reg != '1) ? gap_timer_reg + 1'b1 : gap_timer_reg;
        tick_expired = CMP_W'(gap_inc) >= CMP_W'(cfg.cr_timeout_ms);
        gap_expired  = CMP_W'(gap_timer_reg) >= CMP_W'(cfg.cr_timeout_ms);
        remaining    = {1'b0, declared_length_reg} - bytes_received_reg;
        block_dec    = block_left_reg - 8'd1;

        if (item.op == OP_TICK) begin
            // Advance the Cr timer while a message is open
            if (receiving_reg) begin
                gap_timer_next = gap_inc;
                if (tick_expired) begin
                    res[0]         = mk_error(sender_id_reg, declared_length_reg, ERR_TIMEOUT);
                    res_count      = 2'd1;
                    receiving_next = 1'b0;
                end
            end
        end else if (frame_type == PCI_SF || frame_type == PCI_FF) begin
            // Drop any open reception
            receiving_next = 1'b0;
            if (frame_type == PCI_SF) begin
                if (pci_low != 4'd0 && pci_low <= 4'd7) begin
                    declared_length_next = {4'd0, pci_low};
                    bytes_received_next  = {5'd0, pci_low};
                    res[0] = mk_chunk(item.can_id, {4'd0, pci_low}, 8'd0,
                                      low_bytes(item.frame_data, pci_low[2:0]), pci_low[2:0]);
                    res[1] = mk_plain(KIND_DONE, item.can_id, {4'd0, pci_low});
                    res_count = 2'd2;
                end
            end else if (pci_low == 4'd0 && {1'b0, ff_len} < cfg.max_length) begin
                if (ff_len >= 8'd8) begin
                    receiving_next       = 1'b1;
                    gap_timer_next       = '0;
                    sender_id_next       = item.can_id;
                    declared_length_next = ff_len;
                    bytes_received_next  = BYTES_W'(6);
                    expected_seq_next    = 4'd1;
                    res[0] = mk_chunk(item.can_id, ff_len, 8'd0,
                                      {8'd0, item.frame_data[DATA_W-1:8]}, 3'd6);
                    res[1] = mk_plain(KIND_FIRST, item.can_id, ff_len);
                    res_count = 2'd2;
                    if (item.can_id == cfg.physical_id) begin
                        res[2] = mk_fc(item.can_id, ff_len, FC_CTS,
                                       cfg.block_size, cfg.separation_time);
                        res_count       = 2'd3;
                        block_left_next = cfg.block_size;
                    end
                end
            end else if (item.can_id == cfg.physical_id) begin
                // Reject an oversized first frame with an overflow reply
                res[0] = mk_fc(item.can_id, ff_len, FC_OVERFLOW,
                               cfg.block_size, cfg.separation_time);
                res_count       = 2'd1;
                block_left_next = cfg.block_size;
            end
        end else if (receiving_reg) begin
            if (gap_expired) begin
                res[0]         = mk_error(sender_id_reg, declared_length_reg, ERR_TIMEOUT);
                res_count      = 2'd1;
                receiving_next = 1'b0;
            end else if (frame_type == PCI_CF && item.can_id == sender_id_reg) begin
                gap_timer_next = '0;
                if (pci_low == expected_seq_reg) begin
                    expected_seq_next = expected_seq_reg + 4'd1;
                    if (remaining <= BYTES_W'(7)) begin
                        // Close the message with the tail chunk
                        res[0] = mk_chunk(item.can_id, declared_length_reg,
                                          bytes_received_reg[7:0],
                                          low_bytes(item.frame_data, remaining[2:0]),
                                          remaining[2:0]);
                        res[1] = mk_plain(KIND_DONE, item.can_id, declared_length_reg);
                        res_count           = 2'd2;
                        bytes_received_next = {1'b0, declared_length_reg};
                        receiving_next      = 1'b0;
                    end else begin
                        res[0] = mk_chunk(item.can_id, declared_length_reg,
                                          bytes_received_reg[7:0], item.frame_data, 3'd7);
                        res_count           = 2'd1;
                        bytes_received_next = bytes_received_reg + BYTES_W'(7);
                        block_left_next     = block_dec;
                        // Grant the next block once this one is used up
                        if (block_dec == 8'd0 && cfg.block_size != 8'd0
                            && item.can_id == cfg.physical_id) begin
                            res[1] = mk_fc(item.can_id, declared_length_reg, FC_CTS,
                                           cfg.block_size, cfg.separation_time);
                            res_count       = 2'd2;
                            block_left_next = cfg.block_size;
                        end
                    end
                end else begin
                    res[0]         = mk_error(item.can_id, declared_length_reg, ERR_SEQ);
                    res_count      = 2'd1;
                    receiving_next = 1'b0;
                end
            end
        end

        // Mark the final result of the item
        for (int i = 0; i < RES_MAX; i++) begin
            res[i].last = (res_count == RES_CNT_W'(i + 1));
        end
    end

    // Commit the reception state when the item is taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            receiving_reg       <= 1'b0;
            expected_seq_reg    <= '0;
            bytes_received_reg  <= '0;
            declared_length_reg <= '0;
            sender_id_reg       <= '0;
            block_left_reg      <= BLOCK_SIZE_RST;
            gap_timer_reg       <= '0;
        end else if (fire) begin
            receiving_reg       <= receiving_next;
            expected_seq_reg    <= expected_seq_next;
            bytes_received_reg  <= bytes_received_next;
            declared_length_reg <= declared_length_next;
            sender_id_reg       <= sender_id_next;
            block_left_reg      <= block_left_next;
            gap_timer_reg       <= gap_timer_next;
        end
    end

endmodule

`default_nettype wire

FILE: hw/rtl/crx_outq.sv
`default_nettype none

module crx_outq
    import crx_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 load,
    input  wire result_set_t          load_res,
    input  wire logic [RES_CNT_W-1:0] load_count,
    output      logic                 can_load,
    output      logic                 result_valid,
    input  wire logic                 result_ready,
    output      result_t              result_item
);

    result_t [RES_MAX-1:0]  entries_reg;
    logic [RES_CNT_W-1:0]   count_reg;
    logic [RES_CNT_W-1:0]   head_reg;
    logic                   pop;

    assign result_valid = (count_reg != '0);
    assign result_item  = entries_reg[head_reg];
    assign pop          = result_valid && result_ready;
    // Take a new set once the last buffered item leaves
    assign can_load     = (count_reg == '0) || (count_reg == RES_CNT_W'(1) && pop);

    // Hold result payloads
    always_ff @(posedge clk)
    begin
        if (load) begin
            entries_reg <= load_res;
        end
    end

    // Advance the read pointer as items are taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            count_reg <= '0;
            head_reg  <= '0;
        end else if (load) begin
            count_reg <= load_count;
            head_reg  <= '0;
        end else if (pop) begin
            count_reg <= count_reg - 1'b1;
            head_reg  <= head_reg + 1'b1;
        end
    end

endmodule

`default_nettype wire

FILE: hw/rtl/can_transport_rx_reassembly_core.sv
`default_nettype none

// Channel   Direction  Handshake                   Payload
// frame     in         frame_valid / frame_ready   frame_item (frame_t)
// result    out        result_valid / result_ready result_item (result_t)
// cfg       in         cfg_valid / cfg_ready       cfg_index, cfg_data
//
// An item is decoded in the cycle after it lands in the input register and its
// zero to three results go to the result buffer when it can take a new set, and
// the buffer sends one per cycle over the single output port while result_ready
// is high.
// Reset clears the reception state and loads the register defaults.
// A stalled output holds the buffer; one further item waits in the input register.

module can_transport_rx_reassembly_core
    import crx_pkg::*;
#(
    parameter int TIMER_BITS = TIMER_BITS_DEF
)(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 frame_valid,
    output      logic                 frame_ready,
    input  wire frame_t               frame_item,
    output      logic                 result_valid,
    input  wire logic                 result_ready,
    output      result_t              result_item,
    input  wire logic                 cfg_valid,
    output      logic                 cfg_ready,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [CFG_DAT_W-1:0] cfg_data
);

    logic                 frame_valid_reg;
    frame_t               frame_item_reg;
    cfg_t                 cfg_reg;
    result_set_t          step_res;
    logic [RES_CNT_W-1:0] step_count;
    logic                 can_load;
    logic                 fire;

    assign fire        = frame_valid_reg && can_load;
    assign frame_ready = !frame_valid_reg || fire;
    assign cfg_ready   = 1'b1;

    // Hold the accepted item until it is decoded
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            frame_valid_reg <= 1'b0;
        end else if (frame_ready) begin
            frame_valid_reg <= frame_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (frame_valid && frame_ready) begin
            frame_item_reg <= frame_item;
        end
    end

    // Write configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            cfg_reg.physical_id     <= PHYSICAL_ID_RST;
            cfg_reg.block_size      <= BLOCK_SIZE_RST;
            cfg_reg.separation_time <= SEPARATION_TIME_RST;
            cfg_reg.cr_timeout_ms   <= CR_TIMEOUT_RST;
            cfg_reg.max_length      <= MAX_LENGTH_RST;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                CFG_PHYSICAL_ID:     cfg_reg.physical_id     <= cfg_data[ID_W-1:0];
                CFG_BLOCK_SIZE:      cfg_reg.block_size      <= cfg_data[7:0];
                CFG_SEPARATION_TIME: cfg_reg.separation_time <= cfg_data[7:0];
                CFG_CR_TIMEOUT_MS:   cfg_reg.cr_timeout_ms   <= cfg_data[CR_W-1:0];
                CFG_MAX_LENGTH:      cfg_reg.max_length      <= cfg_data[MAXLEN_W-1:0];
                default: ;
            endcase
        end
    end

    crx_proc #(
        .TIMER_BITS (TIMER_BITS)
    ) u_proc (
        .clk       (clk),
        .rst_n     (rst_n),
        .fire      (fire),
        .item      (frame_item_reg),
        .cfg       (cfg_reg),
        .res       (step_res),
        .res_count (step_count)
    );

    crx_outq u_outq (
        .clk          (clk),
        .rst_n        (rst_n),
        .load         (fire),
        .load_res     (step_res),
        .load_count   (step_count),
        .can_load     (can_load),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result_item  (result_item)
    );

endmodule

`default_nettype wire

FILE: hw/rtl/crx_checker.sv
`default_nettype none

module crx_checker
    import crx_pkg::*;
(
    input wire logic    clk,
    input wire logic    rst_n,
    input wire logic    result_valid,
    input wire logic    result_ready,
    input wire result_t result_item
);

    // Hold a stalled result
    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=> result_valid && $stable(result_item))
        else $error("result changed while stalled");

    // Clear chunk fields outside chunks
    a_chunk_fields: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_item.kind != KIND_CHUNK |->
            result_item.chunk_count == 3'd0 && result_item.chunk_data == '0
            && result_item.chunk_offset == 8'd0)
        else $error("chunk fields set on a non-chunk result");

    // Carry an error code exactly on error results
    a_error_code: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |->
            ((result_item.kind == KIND_ERROR) == (result_item.error_code != ERR_NONE)))
        else $error("error code does not match kind");

    // Clear flow control fields outside flow control
    a_fc_fields: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_item.kind != KIND_FC |->
            result_item.fc_status == 1'b0 && result_item.fc_block == 8'd0
            && result_item.fc_stmin == 8'd0)
        else $error("flow control fields set on another result");

    // End an item with its done result
    a_done_last: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_item.kind == KIND_DONE |-> result_item.last)
        else $error("done result not marked last");

endmodule

bind can_transport_rx_reassembly_core crx_checker u_crx_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result_item  (result_item)
);

`default_nettype wire
